// File: rtl/core/assert_macros.svh
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CRS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("crs assertion failed");

// condition that must be followed by another in the next cycle
`define CRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crs assertion failed");

`endif

// File: rtl/core/crs_pkg.sv
`default_nettype none

package crs_pkg;

   localparam int CountWidth = 16;
   localparam int TickWidth  = 16;
   localparam int DutyWidth  = 8;
   localparam int ZoneWidth  = 3;
   localparam int CmdWidth   = 3;
   localparam int IndexWidth = 3;
   localparam int CmpWidth   = (CountWidth + 1 > TickWidth) ? CountWidth + 1 : TickWidth;

   // zone codes
   localparam logic [ZoneWidth-1:0] ZoneNone   = 3'd0;
   localparam logic [ZoneWidth-1:0] ZoneLeft   = 3'd1;
   localparam logic [ZoneWidth-1:0] ZoneCenter = 3'd2;
   localparam logic [ZoneWidth-1:0] ZoneRight  = 3'd3;
   localparam logic [ZoneWidth-1:0] ZoneMulti  = 3'd4;

   // motor commands
   localparam logic [CmdWidth-1:0] CmdNone  = 3'd0;
   localparam logic [CmdWidth-1:0] CmdStop  = 3'd1;
   localparam logic [CmdWidth-1:0] CmdEstop = 3'd2;
   localparam logic [CmdWidth-1:0] CmdBack  = 3'd3;
   localparam logic [CmdWidth-1:0] CmdRight = 3'd4;
   localparam logic [CmdWidth-1:0] CmdLeft  = 3'd5;

   // register indexes
   localparam logic [IndexWidth-1:0] RegStopTicks = 3'd0;
   localparam logic [IndexWidth-1:0] RegBackTicks = 3'd1;
   localparam logic [IndexWidth-1:0] RegTurnTicks = 3'd2;
   localparam logic [IndexWidth-1:0] RegBackDuty  = 3'd3;
   localparam logic [IndexWidth-1:0] RegTurnDuty  = 3'd4;

   // reset values
   localparam logic [TickWidth-1:0] StopTicksReset = 16'd5;
   localparam logic [TickWidth-1:0] BackTicksReset = 16'd20;
   localparam logic [TickWidth-1:0] TurnTicksReset = 16'd15;
   localparam logic [DutyWidth-1:0] BackDutyReset  = 8'd110;
   localparam logic [DutyWidth-1:0] TurnDutyReset  = 8'd110;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_STOP = 2'd1,
      PH_BACK = 2'd2,
      PH_TURN = 2'd3
   } phase_type;

   typedef struct packed {
      logic [TickWidth-1:0] stop_ticks;
      logic [TickWidth-1:0] back_ticks;
      logic [TickWidth-1:0] turn_ticks;
      logic [DutyWidth-1:0] back_duty;
      logic [DutyWidth-1:0] turn_duty;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/core/crs_regs.sv
`default_nettype none

module crs_regs (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [crs_pkg::IndexWidth-1:0] wr_index,
   input  wire logic [crs_pkg::TickWidth-1:0]  wr_data,
   output crs_pkg::cfg_type                   cfg
);
   import crs_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_ticks <= StopTicksReset;
         cfg_ff.back_ticks <= BackTicksReset;
         cfg_ff.turn_ticks <= TurnTicksReset;
         cfg_ff.back_duty  <= BackDutyReset;
         cfg_ff.turn_duty  <= TurnDutyReset;
      end else if (wr_en) begin
         unique case (wr_index)
            RegStopTicks: cfg_ff.stop_ticks <= wr_data;
            RegBackTicks: cfg_ff.back_ticks <= wr_data;
            RegTurnTicks: cfg_ff.turn_ticks <= wr_data;
            RegBackDuty:  cfg_ff.back_duty  <= wr_data[DutyWidth-1:0];
            RegTurnDuty:  cfg_ff.turn_duty  <= wr_data[DutyWidth-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/collision_reaction_sequencer.sv
// collision_reaction_sequencer
// Bumper reaction sequencer. One req word per control tick carries the hit
// zone (req_zone); one rsp word per req word carries the motor command, its
// duty and whether a reaction sequence is still running after that tick.
// A multi-zone hit gives an emergency stop; a new hit runs stop, backward
// and, for a side hit, a turn away from the struck side.
// Req words are taken when req_valid is high and req_stall low; rsp words
// leave when rsp_valid is high and rsp_stall low.
// A taken word is held in the input register, then processed into the result
// register and offered on rsp from then on. Words are taken at one per
// cycle unless rsp_stall holds the result register, as the phase, zone and
// tick counter registers update together with the result register.
// When rsp_stall is high the result register holds and the input register
// still takes one more word; req_stall rises only while both are full.
// The csr port (csr_valid, csr_ready, csr_index, csr_wdata) writes the five
// timing and duty registers; csr_ready is always high, and writes belong
// only where no word is in flight. An index above four is ignored.
// Reset (synchronous) empties both registers, returns the sequence to idle
// and loads the default tick counts and duties.
`default_nettype none
`include "assert_macros.svh"

module collision_reaction_sequencer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [crs_pkg::ZoneWidth-1:0]  req_zone,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [crs_pkg::CmdWidth-1:0]   rsp_motor_command,
   output      logic [crs_pkg::DutyWidth-1:0]  rsp_duty,
   output      logic                           rsp_active,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [crs_pkg::IndexWidth-1:0] csr_index,
   input  wire logic [crs_pkg::TickWidth-1:0]  csr_wdata
);
   import crs_pkg::*;

   cfg_type cfg;

   logic                  in_valid_ff;
   logic [ZoneWidth-1:0]  in_zone_ff;
   logic                  out_valid_ff;
   logic [CmdWidth-1:0]   out_cmd_ff;
   logic [DutyWidth-1:0]  out_duty_ff;
   logic                  out_active_ff;

   phase_type             phase_ff, phase_in;
   logic [ZoneWidth-1:0]  zone_ff, zone_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic                  out_load;
   logic                  advance;
   logic                  req_take;
   logic [ZoneWidth-1:0]  zone_eff;
   logic                  idle_hold;
   logic                  restart;
   phase_type             work_phase;
   logic [ZoneWidth-1:0]  work_zone;
   logic [CountWidth-1:0] work_count;
   logic [CountWidth:0]   count_inc;
   logic [CountWidth-1:0] count_sat;
   logic [TickWidth-1:0]  limit;
   logic                  done;
   logic [CmdWidth-1:0]   cmd;
   logic [DutyWidth-1:0]  duty;
   logic                  run_zone_ok;
   logic                  out_no_drive;

   crs_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   assign csr_ready = 1'b1;

   // handshake
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   // shared step decode
   assign zone_eff   = (in_zone_ff > ZoneMulti) ? ZoneNone : in_zone_ff;
   assign idle_hold  = (zone_eff == ZoneNone) && (phase_ff == PH_IDLE);
   assign restart    = (zone_eff != ZoneNone) &&
                       ((phase_ff == PH_IDLE) || (zone_eff != zone_ff));
   assign work_phase = restart ? PH_STOP : phase_ff;
   assign work_zone  = restart ? zone_eff : zone_ff;
   assign work_count = restart ? '0 : count_ff;
   assign count_inc  = {1'b0, work_count} + (CountWidth + 1)'(1);
   assign count_sat  = count_inc[CountWidth] ? '1 : count_inc[CountWidth-1:0];

   always_comb begin
      unique case (work_phase)
         PH_STOP: limit = cfg.stop_ticks;
         PH_BACK: limit = cfg.back_ticks;
         PH_TURN: limit = cfg.turn_ticks;
         PH_IDLE: limit = cfg.stop_ticks;
      endcase
   end

   assign done = CmpWidth'(count_inc) >= CmpWidth'(limit);

   // next state
   always_comb begin
      phase_in = work_phase;
      zone_in  = work_zone;
      count_in = count_sat;
      if (zone_eff == ZoneMulti) begin
         phase_in = PH_IDLE;
         zone_in  = ZoneMulti;
         count_in = '0;
      end else if (idle_hold) begin
         phase_in = PH_IDLE;
         zone_in  = ZoneNone;
         count_in = '0;
      end else begin
         unique case (work_phase)
            PH_STOP: begin
               if (done) begin
                  phase_in = PH_BACK;
                  count_in = '0;
               end
            end
            PH_BACK: begin
               if (done && work_zone == ZoneCenter) begin
                  phase_in = PH_IDLE;
                  zone_in  = ZoneNone;
                  count_in = '0;
               end else if (done) begin
                  phase_in = PH_TURN;
                  count_in = '0;
               end
            end
            PH_TURN: begin
               if (done) begin
                  phase_in = PH_IDLE;
                  zone_in  = ZoneNone;
                  count_in = '0;
               end
            end
            PH_IDLE: begin
               phase_in = PH_IDLE;
               count_in = count_ff;
            end
         endcase
      end
   end

   // command for the tick
   always_comb begin
      cmd  = CmdNone;
      duty = '0;
      if (zone_eff == ZoneMulti) begin
         cmd = CmdEstop;
      end else if (!idle_hold) begin
         unique case (work_phase)
            PH_STOP: cmd = CmdStop;
            PH_BACK: begin
               if (done && work_zone == ZoneCenter) begin
                  cmd = CmdStop;
               end else begin
                  cmd  = CmdBack;
                  duty = cfg.back_duty;
               end
            end
            PH_TURN: begin
               priority if (done) begin
                  cmd = CmdStop;
               end else if (work_zone == ZoneLeft) begin
                  cmd  = CmdRight;
                  duty = cfg.turn_duty;
               end else if (work_zone == ZoneRight) begin
                  cmd  = CmdLeft;
                  duty = cfg.turn_duty;
               end else begin
                  cmd = CmdStop;
               end
            end
            PH_IDLE: cmd = CmdNone;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         zone_ff      <= ZoneNone;
         count_ff     <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            phase_ff <= phase_in;
            zone_ff  <= zone_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_zone_ff <= req_zone;
      end
      if (advance) begin
         out_cmd_ff    <= cmd;
         out_duty_ff   <= duty;
         out_active_ff <= (phase_in != PH_IDLE);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_motor_command = out_cmd_ff;
   assign rsp_duty          = out_duty_ff;
   assign rsp_active        = out_active_ff;

   assign run_zone_ok  = (zone_ff == ZoneLeft) || (zone_ff == ZoneCenter) ||
                         (zone_ff == ZoneRight);
   assign out_no_drive = (out_cmd_ff == CmdNone) || (out_cmd_ff == CmdStop) ||
                         (out_cmd_ff == CmdEstop);

   // a running sequence always belongs to a single side or the center
   `CRS_ASSERT(a_active_zone, clock, reset, (phase_ff == PH_IDLE) || run_zone_ok)
   // center hits never reach the turn phase
   `CRS_ASSERT(a_no_center_turn, clock, reset, (phase_ff != PH_TURN) || (zone_ff != ZoneCenter))
   // stop-type commands carry no duty
   `CRS_ASSERT(a_stop_duty, clock, reset, !out_valid_ff || !out_no_drive || (out_duty_ff == '0))
   // a processed word always lands in the result register
   `CRS_ASSERT_NEXT(a_advance_lands, clock, reset, advance, out_valid_ff)

endmodule

`default_nettype wire

// File: dv/tb_collision_reaction_sequencer.sv
`timescale 1ns / 100ps

module tb_collision_reaction_sequencer;
   import crs_pkg::*;

   typedef struct packed {
      logic [CmdWidth-1:0]  cmd;
      logic [DutyWidth-1:0] duty;
      logic                 active;
   } motor_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ZoneWidth-1:0]  req_zone = ZoneNone;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CmdWidth-1:0]   rsp_motor_command;
   logic [DutyWidth-1:0]  rsp_duty;
   logic                  rsp_active;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [IndexWidth-1:0] csr_index = RegStopTicks;
   logic [TickWidth-1:0]  csr_wdata = '0;

   // own copy of the sequencer state and its timing registers
   cfg_type timing_cfg = '{StopTicksReset, BackTicksReset, TurnTicksReset,
                           BackDutyReset, TurnDutyReset};
   phase_type             seq_phase = PH_IDLE;
   logic [ZoneWidth-1:0]  seq_zone = ZoneNone;
   logic [CountWidth-1:0] phase_ticks = '0;

   motor_word_type pending_commands[$];

   int  errors = 0;
   int  ticks_sent = 0;
   int  words_checked = 0;
   int  reg_writes = 0;
   bit  sender_gaps = 1'b1;
   bit  receiver_gaps = 1'b1;
   int  hold_request = 0;
   int  hold_seen = 0;
   int  hold_len = 0;
   int  hold_left = 0;

   collision_reaction_sequencer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_zone          (req_zone),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_motor_command (rsp_motor_command),
      .rsp_duty          (rsp_duty),
      .rsp_active        (rsp_active),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      #6_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // counts one tick of the current phase, saturating at the counter maximum
   function automatic bit phase_over(input logic [TickWidth-1:0] limit);
      logic [CountWidth:0] nxt;
      nxt = {1'b0, phase_ticks} + 1'b1;
      phase_ticks = nxt[CountWidth] ? {CountWidth{1'b1}} : nxt[CountWidth-1:0];
      return nxt >= limit;
   endfunction

   function automatic motor_word_type react_to_tick(input logic [ZoneWidth-1:0] zone_in);
      logic [ZoneWidth-1:0] z;
      motor_word_type w;
      z = (zone_in > ZoneMulti) ? ZoneNone : zone_in;
      w.cmd = CmdNone;
      w.duty = '0;
      if (z == ZoneMulti) begin
         seq_phase = PH_IDLE;
         seq_zone = ZoneMulti;
         phase_ticks = '0;
         w.cmd = CmdEstop;
      end else if (z == ZoneNone && seq_phase == PH_IDLE) begin
         seq_zone = ZoneNone;
         phase_ticks = '0;
      end else begin
         if (z != ZoneNone && (seq_phase == PH_IDLE || z != seq_zone)) begin
            seq_zone = z;
            seq_phase = PH_STOP;
            phase_ticks = '0;
         end
         case (seq_phase)
            PH_STOP: begin
               w.cmd = CmdStop;
               if (phase_over(timing_cfg.stop_ticks)) begin
                  seq_phase = PH_BACK;
                  phase_ticks = '0;
               end
            end
            PH_BACK: begin
               w.cmd = CmdBack;
               w.duty = timing_cfg.back_duty;
               if (phase_over(timing_cfg.back_ticks)) begin
                  if (seq_zone == ZoneCenter) begin
                     seq_phase = PH_IDLE;
                     seq_zone = ZoneNone;
                     phase_ticks = '0;
                     w.cmd = CmdStop;
                     w.duty = '0;
                  end else begin
                     seq_phase = PH_TURN;
                     phase_ticks = '0;
                  end
               end
            end
            PH_TURN: begin
               if (seq_zone == ZoneLeft) begin
                  w.cmd = CmdRight;
                  w.duty = timing_cfg.turn_duty;
               end else if (seq_zone == ZoneRight) begin
                  w.cmd = CmdLeft;
                  w.duty = timing_cfg.turn_duty;
               end else begin
                  w.cmd = CmdStop;
               end
               if (phase_over(timing_cfg.turn_ticks)) begin
                  seq_phase = PH_IDLE;
                  seq_zone = ZoneNone;
                  phase_ticks = '0;
                  w.cmd = CmdStop;
                  w.duty = '0;
               end
            end
            default: ;
         endcase
      end
      w.active = (seq_phase != PH_IDLE);
      return w;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want_v);
      errors++;
      if (errors <= 30)
         $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want_v);
   endtask

   // predict on every accepted tick word
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_commands.push_back(react_to_tick(req_zone));
   end

   always @(posedge clock) begin
      motor_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_commands.size() == 0) begin
            report_mismatch("unexpected response word", 1, 0);
         end else begin
            want = pending_commands.pop_front();
            words_checked++;
            if (rsp_motor_command !== want.cmd)
               report_mismatch("motor_command", rsp_motor_command, want.cmd);
            if (rsp_duty !== want.duty)
               report_mismatch("duty", rsp_duty, want.duty);
            if (rsp_active !== want.active)
               report_mismatch("active", rsp_active, want.active);
         end
      end
   end

   // receiver: random stall, or a long hold-off when a test asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         hold_left <= 0;
         rsp_stall <= receiver_gaps && ($urandom_range(99) < 22);
      end
   end

   task automatic send_tick(input logic [ZoneWidth-1:0] zone);
      while (sender_gaps && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_zone <= zone;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // end any running sequence with a multi hit, then let the pipe empty
   task automatic wait_until_quiet();
      if (seq_phase != PH_IDLE) send_tick(ZoneMulti);
      drain_responses();
   endtask

   task automatic write_register(input logic [IndexWidth-1:0] idx,
                                 input logic [TickWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         RegStopTicks: timing_cfg.stop_ticks = data;
         RegBackTicks: timing_cfg.back_ticks = data;
         RegTurnTicks: timing_cfg.turn_ticks = data;
         RegBackDuty:  timing_cfg.back_duty = data[DutyWidth-1:0];
         RegTurnDuty:  timing_cfg.turn_duty = data[DutyWidth-1:0];
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   // duty writes carry random upper bits that must be dropped
   task automatic program_timing(input logic [TickWidth-1:0] stop_t,
                                 input logic [TickWidth-1:0] back_t,
                                 input logic [TickWidth-1:0] turn_t,
                                 input logic [DutyWidth-1:0] back_d,
                                 input logic [DutyWidth-1:0] turn_d);
      wait_until_quiet();
      write_register(RegStopTicks, stop_t);
      write_register(RegBackTicks, back_t);
      write_register(RegTurnTicks, turn_t);
      write_register(RegBackDuty, {8'($urandom), back_d});
      write_register(RegTurnDuty, {8'($urandom), turn_d});
   endtask

   task automatic run_hit(input logic [ZoneWidth-1:0] zone, input int quiet);
      send_tick(zone);
      repeat (quiet) send_tick(ZoneNone);
   endtask

   task automatic test_zone_cases();
      // idle ticks, out-of-range codes read as none
      send_tick(ZoneNone);
      send_tick(3'd5);
      send_tick(3'd6);
      send_tick(3'd7);
      send_tick(ZoneMulti);
      send_tick(ZoneNone);
      // same zone again is ignored, a different one restarts
      send_tick(ZoneLeft);
      send_tick(ZoneLeft);
      send_tick(ZoneNone);
      send_tick(3'd7);
      send_tick(ZoneRight);
      send_tick(ZoneRight);
      send_tick(ZoneCenter);
      send_tick(ZoneNone);
      send_tick(ZoneMulti);
      send_tick(ZoneCenter);
      send_tick(ZoneMulti);
      send_tick(ZoneMulti);
      drain_responses();
   endtask

   task automatic test_register_extremes();
      // zero ticks behave as one
      program_timing(16'd0, 16'd1, 16'd0, 8'd255, 8'd0);
      write_register(RegTurnDuty + 3'd1, 16'($urandom));
      write_register(RegTurnDuty + 3'd2, 16'($urandom));
      write_register(RegTurnDuty + 3'd3, 16'($urandom));
      run_hit(ZoneLeft, 4);
      run_hit(ZoneRight, 4);
      run_hit(ZoneCenter, 3);
      program_timing(16'd1, 16'd0, 16'd1, 8'd0, 8'd255);
      run_hit(ZoneRight, 4);
      run_hit(ZoneLeft, 3);
      run_hit(ZoneCenter, 2);
      // maximum tick counts: the phase must not end early
      program_timing(16'hFFFF, 16'd2, 16'd2, 8'd17, 8'd200);
      run_hit(ZoneCenter, 30);
      program_timing(16'd1, 16'hFFFF, 16'd2, 8'd90, 8'd33);
      run_hit(ZoneLeft, 30);
      program_timing(16'd1, 16'd1, 16'hFFFF, 8'd64, 8'd128);
      run_hit(ZoneRight, 30);
      wait_until_quiet();
   endtask

   task automatic test_input_backpressure();
      program_timing(16'd2, 16'd3, 16'd2, 8'd77, 8'd150);
      sender_gaps = 1'b0;
      hold_len = 80;
      hold_request++;
      run_hit(ZoneLeft, 12);
      run_hit(ZoneCenter, 10);
      run_hit(ZoneRight, 8);
      sender_gaps = 1'b1;
      drain_responses();
   endtask

   function automatic logic [TickWidth-1:0] pick_ticks();
      int r;
      r = $urandom_range(99);
      if (r < 80) return TickWidth'($urandom_range(0, 6));
      if (r < 96) return TickWidth'($urandom_range(7, 20));
      return TickWidth'($urandom);
   endfunction

   task automatic test_random_reactions(input int n_ticks, input bit reprogram);
      int target;
      int span;
      int quiet;
      int r;
      logic [ZoneWidth-1:0] z;
      target = ticks_sent + n_ticks;
      while (ticks_sent < target) begin
         r = $urandom_range(99);
         if (reprogram && r < 20) begin
            program_timing(pick_ticks(), pick_ticks(), pick_ticks(),
                           8'($urandom), 8'($urandom));
            if ($urandom_range(3) == 0)
               write_register(RegTurnDuty + 3'($urandom_range(1, 3)), 16'($urandom));
         end else if (r < 26) begin
            drain_responses();
         end
         r = $urandom_range(99);
         if (r < 75) z = 3'($urandom_range(1, 3));
         else if (r < 85) z = ZoneMulti;
         else z = 3'($urandom_range(0, 7));
         send_tick(z);
         span = timing_cfg.stop_ticks + timing_cfg.back_ticks + timing_cfg.turn_ticks + 4;
         if (span > 40) span = 40;
         quiet = $urandom_range(0, span);
         repeat (quiet) begin
            r = $urandom_range(99);
            if (r < 85) z = ZoneNone;
            else if (r < 92) z = 3'($urandom_range(5, 7));
            else z = 3'($urandom_range(0, 7));
            send_tick(z);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zone_cases();
      test_random_reactions(80, 1'b0);
      test_register_extremes();
      test_input_backpressure();
      test_random_reactions(450, 1'b1);
      // stretch at full rate on both sides
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      test_random_reactions(150, 1'b1);
      drain_responses();
      repeat (8) @(posedge clock);
      $display("sent %0d ticks, checked %0d response words, %0d register writes",
               ticks_sent, words_checked, reg_writes);
      $display("zones 0-7, zero and full-scale timings, receiver hold-off, sender pauses");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
